/* sv/playfair_digraph_encrypt_assert.svh */
// ----------------------------------------------------------------------------
// Playfair encryptor assertion macros
// Shared forms for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_ENCRYPT_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPT_ASSERT_SVH

// Check that is switched off while reset is held.
`define PF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that also runs across reset.
`define PF_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* sv/pf_pkg.sv */
// ----------------------------------------------------------------------------
// Playfair encryptor package
// Letter codes, item kinds, the command word passed from front to back and
// small helpers for positions in the 5x5 square.
// ----------------------------------------------------------------------------
package pf_pkg;

    localparam logic [4:0] LETTER_J = 5'd9;
    localparam logic [4:0] LETTER_Q = 5'd16;
    localparam logic [4:0] LETTER_X = 5'd23;
    localparam logic [4:0] ALPHABET = 5'd26;
    localparam logic [4:0] CELLS    = 5'd25;
    localparam int unsigned CELL_DEPTH   = 25;
    localparam int unsigned LETTER_DEPTH = 26;

    typedef enum logic [1:0] {
        KIND_KEY     = 2'd0,
        KIND_KEY_END = 2'd1,
        KIND_TEXT    = 2'd2,
        KIND_TEXT_END = 2'd3
    } t_kind;

    typedef enum logic {
        OP_PLACE = 1'b0,
        OP_ENC   = 1'b1
    } t_op;

    // PLACE: a is the letter, b its cell. ENC: a and b form the digraph.
    typedef struct packed {
        t_op        op;
        logic [4:0] a;
        logic [4:0] b;
        logic       last;
    } t_cmd;

    function automatic logic [2:0] row_of(input logic [4:0] p);
        logic [2:0] r;
        if (p >= 5'd20)      r = 3'd4;
        else if (p >= 5'd15) r = 3'd3;
        else if (p >= 5'd10) r = 3'd2;
        else if (p >= 5'd5)  r = 3'd1;
        else                 r = 3'd0;
        return r;
    endfunction

    function automatic logic [2:0] col_of(input logic [4:0] p);
        logic [2:0] r;
        logic [4:0] base;
        r    = row_of(p);
        base = {r, 2'b00} + {2'b00, r};
        return 3'(p - base);
    endfunction

    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        return (v == 3'd4) ? 3'd0 : v + 3'd1;
    endfunction

    function automatic logic [4:0] cell_idx(input logic [2:0] r, input logic [2:0] c);
        return {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

endpackage

/* sv/playfair_digraph_encrypt.sv */
// ----------------------------------------------------------------------------
// Playfair digraph encryptor
// Input channel (i_valid/o_ready) carries a kind and a letter per word; the
// output channel (o_valid/i_ready) carries one encrypted digraph per word.
// A key-end word walks the alphabet to fill the rest of the square, one letter
// per cycle while the queue is not full; no input word is taken during the
// walk. Text letters pair up; each pair becomes an encrypt command in the
// queue, and the back end handles each pair as a position read, a square
// read and the output load, taking no new command from the queue until the
// last pair is loaded into the output register. A completed pair passes the
// queue and these steps in order before it appears at the output.
// Reset clears the front and back control state and the output valid flag;
// the square contents are not cleared, since every cell is rewritten before
// it can be read. While the receiver stalls, the result holds in the output
// register and the queue keeps taking words until it fills.
// ----------------------------------------------------------------------------
module playfair_digraph_encrypt import pf_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_kind,
    input  logic [4:0] i_letter,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [4:0] o_cipher_first,
    output logic [4:0] o_cipher_second,
    output logic       o_message_end
);

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic full;
    logic pop;
    logic empty;

    pf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_kind   (i_kind),
        .i_letter (i_letter),
        .o_push   (push),
        .o_cmd    (push_cmd),
        .i_full   (full)
    );

    pf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty)
    );

    pf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (head_cmd),
        .i_empty         (empty),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_cipher_first  (o_cipher_first),
        .o_cipher_second (o_cipher_second),
        .o_message_end   (o_message_end)
    );

endmodule

/* sv/pf_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports; read data is registered and held while
// the read enable is low.
// ----------------------------------------------------------------------------
module pf_ram #(
    parameter int unsigned WIDTH = 5,
    parameter int unsigned DEPTH = 25,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_raddr0,
    input  logic [AW-1:0]    i_raddr1,
    output logic [WIDTH-1:0] o_rdata0,
    output logic [WIDTH-1:0] o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_rd_en) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

/* sv/pf_front.sv */
// ----------------------------------------------------------------------------
// Playfair encryptor front end
// Accepts input words, tracks the key square fill and the text pairing, and
// issues place and encrypt commands into the queue.
// ----------------------------------------------------------------------------
module pf_front import pf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_kind,
    input  logic [4:0] i_letter,
    output logic       o_push,
    output t_cmd       o_cmd,
    input  logic       i_full
);

    typedef enum logic [1:0] {
        F_RUN  = 2'b01,
        F_FILL = 2'b10
    } t_fstate;

    t_fstate     r_state, n_state;
    logic [25:0] r_used, n_used;
    logic [4:0]  r_count, n_count;
    logic        r_ready, n_ready;
    logic        r_pend, n_pend;
    logic [4:0]  r_pend_letter, n_pend_letter;
    logic [4:0]  r_walk, n_walk;

    logic        accept;
    logic        adv;
    logic [25:0] used_eff;
    logic [4:0]  count_eff;
    t_kind       kind;

    assign kind    = t_kind'(i_kind);
    assign o_ready = (r_state == F_RUN) && !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state       = r_state;
        n_used        = r_used;
        n_count       = r_count;
        n_ready       = r_ready;
        n_pend        = r_pend;
        n_pend_letter = r_pend_letter;
        n_walk        = r_walk;
        o_push        = 1'b0;
        o_cmd         = '{op: OP_PLACE, a: 5'd0, b: 5'd0, last: 1'b0};
        adv           = 1'b0;
        used_eff      = r_used;
        count_eff     = r_count;

        case (r_state)
            F_FILL: begin
                // Walk the alphabet once, placing each letter still unused.
                if (r_walk != LETTER_J && !r_used[r_walk] && r_count < CELLS) begin
                    if (!i_full) begin
                        o_push  = 1'b1;
                        o_cmd   = '{op: OP_PLACE, a: r_walk, b: r_count, last: 1'b0};
                        n_used  = r_used | (26'd1 << r_walk);
                        n_count = r_count + 5'd1;
                        adv     = 1'b1;
                    end
                end else begin
                    adv = 1'b1;
                end
                if (adv) begin
                    if (r_walk == ALPHABET - 5'd1) begin
                        n_ready = 1'b1;
                        n_state = F_RUN;
                    end else begin
                        n_walk = r_walk + 5'd1;
                    end
                end
            end
            F_RUN: begin
                if (accept) begin
                    case (kind)
                        KIND_KEY: begin
                            // A key letter after a finished square opens a new one.
                            if (r_ready) begin
                                used_eff  = '0;
                                count_eff = '0;
                                n_used    = '0;
                                n_count   = '0;
                                n_ready   = 1'b0;
                                n_pend    = 1'b0;
                                n_pend_letter = '0;
                            end
                            if (i_letter < ALPHABET && i_letter != LETTER_J &&
                                !used_eff[i_letter] && count_eff < CELLS) begin
                                o_push  = 1'b1;
                                o_cmd   = '{op: OP_PLACE, a: i_letter, b: count_eff,
                                            last: 1'b0};
                                n_used  = used_eff | (26'd1 << i_letter);
                                n_count = count_eff + 5'd1;
                            end
                        end
                        KIND_KEY_END: begin
                            n_walk  = '0;
                            n_state = F_FILL;
                        end
                        KIND_TEXT: begin
                            if (r_ready && i_letter < ALPHABET) begin
                                if (!r_pend) begin
                                    n_pend        = 1'b1;
                                    n_pend_letter = i_letter;
                                end else if (r_pend_letter == i_letter) begin
                                    // Doubled letter: split with a filler, keep it waiting.
                                    o_push = 1'b1;
                                    o_cmd  = '{op: OP_ENC, a: i_letter,
                                               b: (i_letter == LETTER_X) ? LETTER_Q : LETTER_X,
                                               last: 1'b0};
                                end else begin
                                    o_push = 1'b1;
                                    o_cmd  = '{op: OP_ENC, a: r_pend_letter, b: i_letter,
                                               last: 1'b0};
                                    n_pend        = 1'b0;
                                    n_pend_letter = '0;
                                end
                            end
                        end
                        KIND_TEXT_END: begin
                            if (r_ready && r_pend) begin
                                o_push = 1'b1;
                                o_cmd  = '{op: OP_ENC, a: r_pend_letter, b: LETTER_X,
                                           last: 1'b1};
                                n_pend        = 1'b0;
                                n_pend_letter = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = F_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= F_RUN;
            r_used        <= '0;
            r_count       <= '0;
            r_ready       <= 1'b0;
            r_pend        <= 1'b0;
            r_pend_letter <= '0;
            r_walk        <= '0;
        end else begin
            r_state       <= n_state;
            r_used        <= n_used;
            r_count       <= n_count;
            r_ready       <= n_ready;
            r_pend        <= n_pend;
            r_pend_letter <= n_pend_letter;
            r_walk        <= n_walk;
        end
    end

endmodule

/* sv/pf_queue.sv */
// ----------------------------------------------------------------------------
// Playfair encryptor command queue
// Small first-in first-out buffer of commands between front and back.
// ----------------------------------------------------------------------------
module pf_queue import pf_pkg::*; #(
    parameter int unsigned DEPTH = 2,
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned CW = $clog2(DEPTH + 1)
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

/* sv/pf_back.sv */
// ----------------------------------------------------------------------------
// Playfair encryptor back end
// Holds the square and the letter positions, carries out place commands and
// encrypts digraphs into the output register.
// ----------------------------------------------------------------------------
module pf_back import pf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [4:0] o_cipher_first,
    output logic [4:0] o_cipher_second,
    output logic       o_message_end
);

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_LOOK  = 3'b010,
        B_FETCH = 3'b100
    } t_bstate;

    t_bstate    r_state, n_state;
    logic       r_a_j;
    logic       r_b_j;
    logic       r_last;
    logic       r_out_valid, n_out_valid;
    logic [4:0] r_first;
    logic [4:0] r_second;
    logic       r_end;

    logic       place_we;
    logic       enc_start;
    logic       load_out;
    logic [4:0] pl_rd0, pl_rd1;
    logic [4:0] sq_rd0, sq_rd1;
    logic [4:0] pa, pb;
    logic [2:0] ra, ca, rb, cb;
    logic [4:0] sq_addr0, sq_addr1;

    assign o_pop     = (r_state == B_IDLE) && !i_empty;
    assign place_we  = o_pop && (i_cmd.op == OP_PLACE);
    assign enc_start = o_pop && (i_cmd.op == OP_ENC);
    assign load_out  = (r_state == B_FETCH) && (!r_out_valid || i_ready);

    // Letter position store: indexed by letter, holds its cell.
    pf_ram #(.WIDTH(5), .DEPTH(LETTER_DEPTH)) u_place (
        .i_clk    (i_clk),
        .i_we     (place_we),
        .i_waddr  (i_cmd.a),
        .i_wdata  (i_cmd.b),
        .i_rd_en  (enc_start),
        .i_raddr0 (i_cmd.a),
        .i_raddr1 (i_cmd.b),
        .o_rdata0 (pl_rd0),
        .o_rdata1 (pl_rd1)
    );

    // Square store: indexed by cell, holds its letter.
    pf_ram #(.WIDTH(5), .DEPTH(CELL_DEPTH)) u_square (
        .i_clk    (i_clk),
        .i_we     (place_we),
        .i_waddr  (i_cmd.b),
        .i_wdata  (i_cmd.a),
        .i_rd_en  (r_state == B_LOOK),
        .i_raddr0 (sq_addr0),
        .i_raddr1 (sq_addr1),
        .o_rdata0 (sq_rd0),
        .o_rdata1 (sq_rd1)
    );

    // J is never placed, so its position is the corner cell.
    always_comb begin
        pa = r_a_j ? 5'd0 : pl_rd0;
        pb = r_b_j ? 5'd0 : pl_rd1;
        ra = row_of(pa);
        ca = col_of(pa);
        rb = row_of(pb);
        cb = col_of(pb);
        if (ra == rb) begin
            sq_addr0 = cell_idx(ra, wrap_inc(ca));
            sq_addr1 = cell_idx(rb, wrap_inc(cb));
        end else if (ca == cb) begin
            sq_addr0 = cell_idx(wrap_inc(ra), ca);
            sq_addr1 = cell_idx(wrap_inc(rb), cb);
        end else begin
            sq_addr0 = cell_idx(ra, cb);
            sq_addr1 = cell_idx(rb, ca);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            B_IDLE: begin
                if (enc_start) begin
                    n_state = B_LOOK;
                end
            end
            B_LOOK: begin
                n_state = B_FETCH;
            end
            B_FETCH: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enc_start) begin
            r_a_j  <= (i_cmd.a == LETTER_J);
            r_b_j  <= (i_cmd.b == LETTER_J);
            r_last <= i_cmd.last;
        end
        if (load_out) begin
            r_first  <= sq_rd0;
            r_second <= sq_rd1;
            r_end    <= r_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_cipher_first  = r_first;
    assign o_cipher_second = r_second;
    assign o_message_end   = r_end;

endmodule

/* sv/pf_checker.sv */
// ----------------------------------------------------------------------------
// Playfair encryptor port checker
// Concurrent checks on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
`include "playfair_digraph_encrypt_assert.svh"

module pf_checker import pf_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [1:0] i_kind,
    input logic [4:0] i_letter,
    input logic       o_valid,
    input logic       i_ready,
    input logic [4:0] o_cipher_first,
    input logic [4:0] o_cipher_second,
    input logic       o_message_end
);

    // No output word may be left over from before reset.
    `PF_ASSERT_RST(a_reset_idle, !i_rst_n |=> !o_valid, "output valid after reset")

    `PF_ASSERT(a_valid_holds, o_valid && !i_ready |=> o_valid, "output word dropped")

    `PF_ASSERT(a_payload_holds, o_valid && !i_ready |=> $stable(o_cipher_first) &&
        $stable(o_cipher_second) && $stable(o_message_end), "stalled word changed")

    // Cipher letters come from the square, which never holds J or a bad code.
    `PF_ASSERT(a_letters_valid, o_valid |-> o_cipher_first < ALPHABET &&
        o_cipher_second < ALPHABET && o_cipher_first != LETTER_J &&
        o_cipher_second != LETTER_J, "cipher letter outside the square")

endmodule

bind playfair_digraph_encrypt pf_checker u_pf_checker (.*);
